### design/primitive_index_assembler_unit_macros.svh
// Assertion macros used by the checker.
`ifndef PRIMITIVE_INDEX_ASSEMBLER_UNIT_MACROS_SVH
`define PRIMITIVE_INDEX_ASSEMBLER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PIA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("primitive assembler check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PIA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("primitive assembler check failed");

`endif

### design/pia_pkg.sv
`default_nettype none
package pia_pkg;

	localparam int INDEX_BITS = 32;
	localparam logic [31:0] INDEX_MASK = 32'((64'd1 << INDEX_BITS) - 64'd1);

	localparam int ADDR_BITS = 4;

	localparam logic [1:0] REG_TOPOLOGY     = 2'd0;
	localparam logic [1:0] REG_INDEX_SOURCE = 2'd1;
	localparam logic [1:0] REG_INDEX_FORMAT = 2'd2;

	localparam logic [2:0] TOPO_POINTS     = 3'd0;
	localparam logic [2:0] TOPO_LINE_LIST  = 3'd1;
	localparam logic [2:0] TOPO_LINE_STRIP = 3'd2;
	localparam logic [2:0] TOPO_TRI_LIST   = 3'd3;
	localparam logic [2:0] TOPO_TRI_STRIP  = 3'd4;
	localparam logic [2:0] TOPO_TRI_FAN    = 3'd5;

	localparam logic SRC_INPUT  = 1'b0;
	localparam logic SRC_LINEAR = 1'b1;

	localparam logic FMT_16 = 1'b0;
	localparam logic FMT_32 = 1'b1;

	typedef struct packed {
		logic [2:0] topology;
		logic       index_source;
		logic       index_format;
	} cfg_t;

	typedef struct packed {
		logic        emit;
		logic [31:0] corner_a;
		logic [31:0] corner_b;
		logic [31:0] corner_c;
	} prim_t;

endpackage
`default_nettype wire

### design/pia_if.sv
`default_nettype none
interface pia_vtx_if;
	logic        valid;
	logic        ready;
	logic [31:0] vertex_index;
	logic        draw_start;

	modport source (output valid, output vertex_index, output draw_start, input ready);
	modport sink (input valid, input vertex_index, input draw_start, output ready);
endinterface

interface pia_prim_if;
	logic        valid;
	logic        ready;
	logic [31:0] corner_a;
	logic [31:0] corner_b;
	logic [31:0] corner_c;

	modport source (output valid, output corner_a, output corner_b, output corner_c,
		input ready);
	modport sink (input valid, input corner_a, input corner_b, input corner_c,
		output ready);
endinterface
`default_nettype wire

### design/pia_regs.sv
`default_nettype none
module pia_regs
	import pia_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [ADDR_BITS-1:0] paddr,
	input  wire logic [31:0]          pwdata,
	output logic      [31:0]          prdata,
	output logic                      pready,
	output cfg_t                      cfg
);

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.topology     <= TOPO_TRI_LIST;
			cfg_q.index_source <= SRC_INPUT;
			cfg_q.index_format <= FMT_32;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_TOPOLOGY:     cfg_q.topology     <= pwdata[2:0];
				REG_INDEX_SOURCE: cfg_q.index_source <= pwdata[0];
				REG_INDEX_FORMAT: cfg_q.index_format <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_TOPOLOGY:     prdata = {29'd0, cfg_q.topology};
			REG_INDEX_SOURCE: prdata = {31'd0, cfg_q.index_source};
			REG_INDEX_FORMAT: prdata = {31'd0, cfg_q.index_format};
			default:          prdata = 32'd0;
		endcase
	end

endmodule
`default_nettype wire

### design/pia_asm.sv
`default_nettype none
module pia_asm
	import pia_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        step,
	input  wire logic [31:0] vertex_index,
	input  wire logic        draw_start,
	input  wire cfg_t        cfg,
	output prim_t            prim
);

	logic [31:0] fan_anchor_q, older_q, newer_q, counter_q;
	logic [1:0]  phase_q;
	logic        parity_q;

	logic [31:0] fan_anchor_d, older_d, newer_d;
	logic [1:0]  phase_d, phase_e;
	logic        parity_d, parity_e;
	logic [31:0] counter_e, v_raw, v;

	assign phase_e   = draw_start ? 2'd0 : phase_q;
	assign parity_e  = draw_start ? 1'b0 : parity_q;
	assign counter_e = draw_start ? 32'd0 : counter_q;
	assign v_raw     = (cfg.index_format == FMT_16) ? {16'd0, vertex_index[15:0]} : vertex_index;
	assign v         = ((cfg.index_source == SRC_LINEAR) ? counter_e : v_raw) & INDEX_MASK;

	always_comb begin
		fan_anchor_d = fan_anchor_q;
		older_d      = older_q;
		newer_d      = newer_q;
		phase_d      = phase_e;
		parity_d     = parity_e;
		prim         = '{emit: 1'b0, corner_a: v, corner_b: v, corner_c: v};
		case (cfg.topology)
			TOPO_POINTS: begin
				prim.emit = 1'b1;
			end
			TOPO_LINE_LIST: begin
				if (phase_e == 2'd0) begin
					older_d = v;
					phase_d = 2'd1;
				end else begin
					prim.emit     = 1'b1;
					prim.corner_a = older_q;
					phase_d       = 2'd0;
				end
			end
			TOPO_LINE_STRIP: begin
				if (phase_e != 2'd0) begin
					prim.emit     = 1'b1;
					prim.corner_a = newer_q;
				end else begin
					phase_d = 2'd1;
				end
				newer_d = v;
			end
			TOPO_TRI_LIST: begin
				if (phase_e == 2'd0) begin
					older_d = v;
					phase_d = 2'd1;
				end else if (phase_e == 2'd1) begin
					newer_d = v;
					phase_d = 2'd2;
				end else begin
					prim.emit     = 1'b1;
					prim.corner_a = older_q;
					prim.corner_b = newer_q;
					phase_d       = 2'd0;
				end
			end
			TOPO_TRI_STRIP: begin
				if (phase_e >= 2'd2) begin
					prim.emit     = 1'b1;
					prim.corner_a = older_q;
					if (parity_e) begin
						prim.corner_c = newer_q;
					end else begin
						prim.corner_b = newer_q;
					end
					parity_d = ~parity_e;
				end else begin
					phase_d = phase_e + 2'd1;
				end
				older_d = newer_q;
				newer_d = v;
			end
			TOPO_TRI_FAN: begin
				if (phase_e == 2'd0) begin
					fan_anchor_d = v;
					phase_d      = 2'd1;
				end else if (phase_e == 2'd1) begin
					newer_d = v;
					phase_d = 2'd2;
				end else begin
					prim.emit     = 1'b1;
					prim.corner_a = newer_q;
					prim.corner_c = fan_anchor_q;
					newer_d       = v;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fan_anchor_q <= 32'd0;
			older_q      <= 32'd0;
			newer_q      <= 32'd0;
			phase_q      <= 2'd0;
			parity_q     <= 1'b0;
			counter_q    <= 32'd0;
		end else if (step) begin
			fan_anchor_q <= fan_anchor_d;
			older_q      <= older_d;
			newer_q      <= newer_d;
			phase_q      <= phase_d;
			parity_q     <= parity_d;
			counter_q    <= counter_e + 32'd1;
		end
	end

endmodule
`default_nettype wire

### design/primitive_index_assembler_unit.sv
// Channel   Dir  Payload                            Transfer
// vtx       in   vertex_index[31:0], draw_start     vtx.valid && vtx.ready
// prim      out  corner_a/b/c[31:0]                 prim.valid && prim.ready
// cfg       in   APB, regs at 0x0, 0x4, 0x8         psel && penable && pwrite
//
// One vertex per cycle sustained unless the result stalls; the vertex that
// completes a primitive passes the input, then the result register.
// The assembly state advances as a vertex leaves the input register.
// arst_n clears the assembly history, the linear counter and both valid bits.
// A stalled result holds the input register; vtx.ready drops only then.
`default_nettype none
module primitive_index_assembler_unit
	import pia_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [ADDR_BITS-1:0] paddr,
	input  wire logic [31:0]          pwdata,
	output logic      [31:0]          prdata,
	output logic                      pready,
	pia_vtx_if.sink                   vtx,
	pia_prim_if.source                prim
);

	cfg_t  cfg;
	prim_t res;

	logic        valid_s1;
	logic [31:0] vertex_index_s1;
	logic        draw_start_s1;
	logic        valid_s2;
	logic [31:0] corner_a_s2, corner_b_s2, corner_c_s2;
	logic        adv_s1, step;

	pia_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign adv_s1    = !valid_s2 || prim.ready;
	assign step      = valid_s1 && adv_s1;
	assign vtx.ready = !valid_s1 || adv_s1;

	pia_asm u_asm (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.vertex_index (vertex_index_s1),
		.draw_start   (draw_start_s1),
		.cfg          (cfg),
		.prim         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (vtx.ready) begin
			valid_s1 <= vtx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (vtx.ready && vtx.valid) begin
			vertex_index_s1 <= vtx.vertex_index;
			draw_start_s1   <= vtx.draw_start;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= valid_s1 && res.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res.emit) begin
			corner_a_s2 <= res.corner_a;
			corner_b_s2 <= res.corner_b;
			corner_c_s2 <= res.corner_c;
		end
	end

	assign prim.valid    = valid_s2;
	assign prim.corner_a = corner_a_s2;
	assign prim.corner_b = corner_b_s2;
	assign prim.corner_c = corner_c_s2;

endmodule
`default_nettype wire

### design/pia_checker.sv
`default_nettype none
`include "primitive_index_assembler_unit_macros.svh"
module pia_checker
	import pia_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        vtx_valid,
	input wire logic        vtx_ready,
	input wire logic        prim_valid,
	input wire logic        prim_ready,
	input wire logic [31:0] corner_a,
	input wire logic [31:0] corner_b,
	input wire logic [31:0] corner_c
);

	logic        prim_stall;
	logic        vtx_xfer;
	logic [95:0] corners;

	assign prim_stall = prim_valid && !prim_ready;
	assign vtx_xfer   = vtx_valid && vtx_ready;
	assign corners    = {corner_a, corner_b, corner_c};

	`PIA_ASSERT_NEXT(a_prim_hold, clk, arst_n, prim_stall, prim_valid && $stable(corners))
	`PIA_ASSERT_NOW(a_ready_only_on_stall, clk, arst_n, !vtx_ready, prim_stall)
	`PIA_ASSERT_NOW(a_result_has_source, clk, arst_n, $rose(prim_valid), $past(vtx_xfer, 2))

endmodule

bind primitive_index_assembler_unit pia_checker u_pia_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.vtx_valid  (vtx.valid),
	.vtx_ready  (vtx.ready),
	.prim_valid (prim.valid),
	.prim_ready (prim.ready),
	.corner_a   (prim.corner_a),
	.corner_b   (prim.corner_b),
	.corner_c   (prim.corner_c)
);
`default_nettype wire
